/* rtl/lfu_pkg.sv */
// Shared constants and types for the LFU cache with LRU tie-break.
// No dependencies; used by lfu_cache_lru_tiebreak.
package lfu_pkg;

    // Default number of slots
    localparam int ENTRIES_DEF = 16;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 16;
    localparam int CAP_W = 5;

    // Saturation point of the use count
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Read data on a get miss and on a put
    localparam logic [VAL_W-1:0] READ_MISS = '1;
    localparam logic [VAL_W-1:0] READ_NONE = '0;

    // Command codes
    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    // Kind of rank update pass
    typedef enum logic {
        UPD_TOUCH  = 1'b0,
        UPD_INSERT = 1'b1
    } t_upd;

endpackage

/* rtl/lfu_cache_lru_tiebreak.sv */
// LFU cache, LRU among equal counts; depends on lfu_pkg and lfu_ram. A get miss or a put
// with capacity zero runs the scan only; commands that change ranks also run the rank
// pass, and both passes walk one slot per cycle. One command at a time: the next is taken
// only after the last one has finished, later while a result waits.
// Reset (synchronous, active low) clears the valid bits and sets capacity to 16.
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]       i_cfg_data,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic signed [lfu_pkg::KEY_W-1:0] i_lookup_key,
    input  logic signed [lfu_pkg::VAL_W-1:0] i_write_value,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic signed [lfu_pkg::VAL_W-1:0] o_read_value,
    output logic                            o_evicted
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = IW;
    localparam int KW = lfu_pkg::KEY_W;
    localparam int VW = lfu_pkg::VAL_W;
    localparam int NW = lfu_pkg::CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // command held for the whole sequence
    lfu_pkg::t_cmd   r_cmd;
    logic [KW-1:0]   r_key;
    logic [VW-1:0]   r_val;
    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic [ENTRIES-1:0] r_valid;

    // slot walker: issue counter and data-phase index
    logic [CW-1:0]   r_iss;
    logic            r_pv;
    logic [IW-1:0]   r_pidx;

    // scan results
    logic            r_found;
    logic [IW-1:0]   r_fidx;
    logic [RW-1:0]   r_frank;
    logic [NW-1:0]   r_fcnt;
    logic [CW-1:0]   r_used;
    logic            r_vic_ok;
    logic [IW-1:0]   r_vidx;
    logic [NW-1:0]   r_vcnt;
    logic [RW-1:0]   r_vrank;
    logic            r_free_ok;
    logic [IW-1:0]   r_fridx;

    // update pass control
    lfu_pkg::t_upd   r_upd;
    logic [IW-1:0]   r_tgt;
    logic [RW-1:0]   r_tgt_rank;
    logic            r_evict;

    // output register
    logic            r_out_valid;
    logic            r_hit;
    logic [VW-1:0]   r_rdata;
    logic            r_ev_out;

    // RAM ports
    logic [KW-1:0]   key_q;
    logic [VW-1:0]   val_q;
    logic [NW-1:0]   cnt_q;
    logic [RW-1:0]   rank_q;
    logic            key_we, val_we, cnt_we, rank_we;
    logic [IW-1:0]   wr_idx;
    logic [VW-1:0]   val_wd;
    logic [NW-1:0]   cnt_wd;
    logic [RW-1:0]   rank_wd;
    logic [IW-1:0]   rd_idx;

    // decision terms
    logic [CW-1:0]   cap_eff;
    logic            put_miss;
    logic            dec_evict;
    logic [IW-1:0]   ins_idx;
    logic            issue_more;
    logic            last_data;
    logic            out_free;

    assign rd_idx     = r_iss[IW-1:0];
    assign issue_more = (r_iss < CW'(ENTRIES));
    assign last_data  = r_pv && (r_pidx == IW'(ENTRIES - 1));
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // effective capacity, saturated at the slot count
    assign cap_eff = (32'(r_cap) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cap);

    // put of a new key with inserts enabled
    assign put_miss  = (r_cmd == lfu_pkg::CMD_PUT) && !r_found && (cap_eff != '0);
    assign dec_evict = put_miss && (r_used >= cap_eff) && r_vic_ok;
    assign ins_idx   = (dec_evict && (!r_free_ok || (r_vidx < r_fridx))) ? r_vidx : r_fridx;

    // slot RAM write ports: key/value/count in decide, rank in the update pass
    always_comb begin
        key_we  = 1'b0;
        val_we  = 1'b0;
        cnt_we  = 1'b0;
        wr_idx  = r_fidx;
        val_wd  = r_val;
        cnt_wd  = (r_fcnt == lfu_pkg::CNT_MAX) ? r_fcnt : r_fcnt + NW'(1);
        if (r_state == ST_DECIDE) begin
            priority if (r_found) begin
                // hit: bump count, put sets value; zero-capacity put writes nothing
                cnt_we = 1'b1;
                val_we = (r_cmd == lfu_pkg::CMD_PUT) && (cap_eff != '0);
                cnt_we = (r_cmd == lfu_pkg::CMD_GET) || (cap_eff != '0);
            end else if (put_miss) begin
                key_we = 1'b1;
                val_we = 1'b1;
                cnt_we = 1'b1;
                wr_idx = ins_idx;
                cnt_wd = NW'(1);
            end else begin
                cnt_we = 1'b0;
            end
        end
    end

    // new rank for the slot in the data phase of the update pass
    always_comb begin
        rank_we = (r_state == ST_UPDATE) && r_pv && r_valid[r_pidx];
        priority if (r_pidx == r_tgt) begin
            rank_wd = '0;
        end else if (r_upd == lfu_pkg::UPD_TOUCH) begin
            rank_wd = (rank_q < r_tgt_rank) ? rank_q + RW'(1) : rank_q;
        end else begin
            rank_wd = (r_evict && (rank_q > r_vrank)) ? rank_q : rank_q + RW'(1);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (last_data) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_found) begin
                    n_state = ((r_cmd == lfu_pkg::CMD_GET) || (cap_eff != '0))
                              ? ST_UPDATE : ST_FINISH;
                end else begin
                    n_state = put_miss ? ST_UPDATE : ST_FINISH;
                end
            end
            ST_UPDATE: if (last_data) n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_cap       <= lfu_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            // walker pipeline during both passes
            if ((r_state == ST_SCAN) || (r_state == ST_UPDATE)) begin
                r_pv <= issue_more;
            end else begin
                r_pv <= 1'b0;
            end
            // valid bits change only when a new key goes in
            if ((r_state == ST_DECIDE) && put_miss) begin
                if (dec_evict) begin
                    r_valid[r_vidx] <= 1'b0;
                end
                r_valid[ins_idx] <= 1'b1;
            end
            // result register handshake
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cmd     <= lfu_pkg::t_cmd'(i_command);
                r_key     <= i_lookup_key;
                r_val     <= i_write_value;
                r_iss     <= '0;
                r_found   <= 1'b0;
                r_used    <= '0;
                r_vic_ok  <= 1'b0;
                r_free_ok <= 1'b0;
                r_evict   <= 1'b0;
            end
            ST_SCAN: begin
                if (issue_more) begin
                    r_iss <= r_iss + CW'(1);
                end
                r_pidx <= rd_idx;
                // one slot per cycle: match, occupancy, victim, first free slot
                if (r_pv) begin
                    if (r_valid[r_pidx]) begin
                        r_used <= r_used + CW'(1);
                        if (!r_found && (key_q == r_key)) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_pidx;
                            r_frank <= rank_q;
                            r_fcnt  <= cnt_q;
                        end
                        if (!r_vic_ok || (cnt_q < r_vcnt) ||
                            ((cnt_q == r_vcnt) && (rank_q > r_vrank))) begin
                            r_vic_ok <= 1'b1;
                            r_vidx   <= r_pidx;
                            r_vcnt   <= cnt_q;
                            r_vrank  <= rank_q;
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_fridx   <= r_pidx;
                    end
                end
            end
            ST_DECIDE: begin
                r_iss   <= '0;
                r_evict <= dec_evict;
                if (r_found) begin
                    r_upd      <= lfu_pkg::UPD_TOUCH;
                    r_tgt      <= r_fidx;
                    r_tgt_rank <= r_frank;
                end else begin
                    r_upd      <= lfu_pkg::UPD_INSERT;
                    r_tgt      <= ins_idx;
                    r_tgt_rank <= '0;
                end
            end
            ST_UPDATE: begin
                if (issue_more) begin
                    r_iss <= r_iss + CW'(1);
                end
                r_pidx <= rd_idx;
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_hit    <= r_found;
                    r_ev_out <= r_evict;
                    if (r_cmd == lfu_pkg::CMD_GET) begin
                        r_rdata <= r_found ? val_q : lfu_pkg::READ_MISS;
                    end else begin
                        r_rdata <= lfu_pkg::READ_NONE;
                    end
                end
            end
            default: begin
                r_iss <= '0;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;
    assign o_evicted    = r_ev_out;

    // slot storage
    lfu_ram #(.WIDTH(KW), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(wr_idx),
        .i_wdata(r_key),
        .i_raddr(rd_idx),
        .o_rdata(key_q)
    );

    // value is read at the matched slot only
    lfu_ram #(.WIDTH(VW), .DEPTH(ENTRIES), .AW(IW)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(wr_idx),
        .i_wdata(val_wd),
        .i_raddr(r_fidx),
        .o_rdata(val_q)
    );

    lfu_ram #(.WIDTH(NW), .DEPTH(ENTRIES), .AW(IW)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(wr_idx),
        .i_wdata(cnt_wd),
        .i_raddr(rd_idx),
        .o_rdata(cnt_q)
    );

    lfu_ram #(.WIDTH(RW), .DEPTH(ENTRIES), .AW(IW)) u_rank_ram (
        .i_clk  (i_clk),
        .i_we   (rank_we),
        .i_waddr(r_pidx),
        .i_wdata(rank_wd),
        .i_raddr(rd_idx),
        .o_rdata(rank_q)
    );

    // checks
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) && r_found |-> r_valid[r_fidx])
        else $error("matched slot is not valid");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> (32'(r_used) <= 32'(ENTRIES)))
        else $error("occupancy count exceeds slot count");

    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) && put_miss |=> r_valid[r_tgt])
        else $error("inserted slot not marked valid");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_hit)
        else $error("eviction reported on a hit");

endmodule

/* rtl/lfu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced by lfu_cache_lru_tiebreak for slot storage.
module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/lfu_cache_checker.sv */
// Checker for the LFU cache: watches the command, result and capacity ports,
// predicts each result from its own copy of the cache and compares in order.
// Depends on lfu_pkg.
module lfu_cache_checker #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_command,
    input  logic [lfu_pkg::KEY_W-1:0]    i_lookup_key,
    input  logic [lfu_pkg::VAL_W-1:0]    i_write_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_hit,
    input  logic [lfu_pkg::VAL_W-1:0]    i_read_value,
    input  logic                         i_evicted,
    output int                           o_mismatches,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_cache_reply;

    // Shadow copy of the cache
    logic [CAP_W-1:0] capacity = CAP_RESET;
    logic             slot_live [ENTRIES];
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_data [ENTRIES];
    logic [CNT_W-1:0] use_count [ENTRIES];
    int               lru_rank  [ENTRIES];

    t_cache_reply expected_replies [$];
    int           mismatches = 0;

    assign o_mismatches = mismatches;

    // A use: entry becomes most recent, count goes up unless saturated
    function automatic void bump_entry(int s);
        int r;
        r = lru_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != s && lru_rank[i] < r)
                lru_rank[i]++;
        lru_rank[s] = 0;
        if (use_count[s] != CNT_MAX)
            use_count[s]++;
    endfunction

    // Apply one command to the shadow cache and return the result it gives
    function automatic t_cache_reply predict_access(t_cmd cmd, logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] val);
        t_cache_reply reply;
        int found, used, victim, free_slot, cap;
        found     = -1;
        used      = 0;
        victim    = -1;
        free_slot = -1;
        cap       = (int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity);
        reply     = '{hit: 1'b0, read_value: READ_NONE, evicted: 1'b0};

        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i]) begin
                used++;
                if (found < 0 && slot_key[i] == key)
                    found = i;
            end
        end

        if (cmd == CMD_GET) begin
            if (found >= 0) begin
                reply.read_value = slot_data[found];
                bump_entry(found);
            end else begin
                reply.read_value = READ_MISS;
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                slot_data[found] = val;
                bump_entry(found);
            end else begin
                // full: drop the lowest count, least recent among equals
                if (used >= cap) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_live[i] && (victim < 0 ||
                                use_count[i] < use_count[victim] ||
                                (use_count[i] == use_count[victim] &&
                                 lru_rank[i] > lru_rank[victim])))
                            victim = i;
                    if (victim >= 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_live[i] && lru_rank[i] > lru_rank[victim])
                                lru_rank[i]--;
                        slot_live[victim] = 1'b0;
                        reply.evicted     = 1'b1;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (!slot_live[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_live[i])
                            lru_rank[i]++;
                    slot_live[free_slot] = 1'b1;
                    slot_key[free_slot]  = key;
                    slot_data[free_slot] = val;
                    use_count[free_slot] = 1;
                    lru_rank[free_slot]  = 0;
                end
            end
        end

        reply.hit = (found >= 0);
        return reply;
    endfunction

    // Track accepted items and check results in order
    always @(posedge i_clk) begin
        t_cache_reply want;
        if (!i_rst_n) begin
            capacity = CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
                slot_live[i] = 1'b0;
            expected_replies.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_replies.push_back(predict_access(t_cmd'(i_command),
                                                          i_lookup_key, i_write_value));
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result with none expected: hit %0b value %h evicted %0b",
                             $time, i_hit, i_read_value, i_evicted);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want.hit, i_hit);
                        mismatches++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, want.read_value, i_read_value);
                        mismatches++;
                    end
                    if (i_evicted !== want.evicted) begin
                        $display("%0t: evicted mismatch, expected %0b, got %0b",
                                 $time, want.evicted, i_evicted);
                        mismatches++;
                    end
                end
            end
        end
        o_pending = expected_replies.size();
    end

endmodule

/* bench/tb.sv */
// Top of the LFU cache bench: clock, reset, command and capacity stimulus,
// result-side back-pressure and the verdict.
// Depends on lfu_pkg, lfu_cache_lru_tiebreak and lfu_cache_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 2*ENTRIES_DEF + 8;
    localparam int SINK_HOLD    = 400;

    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]    i_cfg_data    = CAP_RESET;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic                i_command     = CMD_GET;
    logic [KEY_W-1:0]    i_lookup_key  = '0;
    logic [VAL_W-1:0]    i_write_value = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic                o_hit;
    logic [VAL_W-1:0]    o_read_value;
    logic                o_evicted;

    int mismatches;
    int pending;
    int cycles_run    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_no      = -1;
    bit sink_held     = 1'b0;

    logic [KEY_W-1:0] key_pool [32];
    int               pool_size = 1;

    always #1 i_clk = ~i_clk;

    lfu_cache_lru_tiebreak dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted)
    );

    lfu_cache_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_hit         (o_hit),
        .i_read_value  (o_read_value),
        .i_evicted     (o_evicted),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Offer one item after a random gap, hold it until taken
    task automatic issue_command(t_cmd cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_lookup_key  <= key;
        i_write_value <= val;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold in phase 7, one of the no-idle phases
    initial begin
        forever begin
            if (phase_no == 7 && !sink_held) begin
                sink_held = 1'b1;
                repeat (SINK_HOLD) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge i_clk);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int cap;
        int eff_cap;
        t_cmd cmd;
        logic [KEY_W-1:0] key;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two slots: tie on count goes to the least recent, then count decides
        set_capacity(5'd2);
        issue_command(CMD_PUT, KEY_MIN, 32'h7FFF_FFFF);
        issue_command(CMD_PUT, KEY_MAX, 32'h8000_0000);
        issue_command(CMD_PUT, KEY_ZERO, 32'h0000_0000);
        issue_command(CMD_GET, KEY_MIN, 32'hFFFF_FFFF);
        issue_command(CMD_GET, KEY_MAX, 32'h0000_0000);
        issue_command(CMD_PUT, KEY_ONES, 32'h5A5A_5A5A);
        issue_command(CMD_PUT, KEY_ONES, 32'hFFFF_FFFF);
        issue_command(CMD_GET, KEY_ONES, 32'h1234_5678);
        issue_command(CMD_GET, KEY_MAX, 32'h0000_0000);
        issue_command(CMD_PUT, KEY_MIN, 32'hA5A5_A5A5);
        issue_command(CMD_GET, KEY_ONES, 32'h0000_0000);
        wait_drained();

        // capacity zero: puts change nothing, gets still hit what is left
        set_capacity(5'd0);
        issue_command(CMD_PUT, KEY_MAX, 32'h0000_007B);
        issue_command(CMD_PUT, KEY_ZERO, 32'h0000_0001);
        issue_command(CMD_GET, KEY_MAX, 32'h0000_0000);
        issue_command(CMD_GET, KEY_ZERO, 32'h0000_0000);
        wait_drained();

        // capacity above the slot count, then lowered below the fill level
        set_capacity(5'd31);
        for (int i = 0; i < 4; i++)
            issue_command(CMD_PUT, 32'd100 + i, $urandom);
        wait_drained();
        set_capacity(5'd1);
        issue_command(CMD_PUT, 32'd200, $urandom);
        issue_command(CMD_GET, 32'd200, $urandom);
        issue_command(CMD_PUT, 32'd201, $urandom);
        wait_drained();

        // random phases over several capacities and idling patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0: begin send_idle_pct = 35; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            wait_drained();
            case (phase)
                0: cap = 16;
                1: cap = 31;
                2: cap = 1;
                3: cap = 4;
                4: cap = 0;
                5: cap = 8;
                6: cap = 3;
                7: cap = 16;
                default: cap = $urandom_range(2, 15);
            endcase
            set_capacity(cap[CAP_W-1:0]);
            phase_no = phase;

            // keep the old keys when inserts are off so gets find leftovers
            if (cap != 0) begin
                eff_cap   = (cap > ENTRIES_DEF) ? ENTRIES_DEF : cap;
                pool_size = eff_cap + $urandom_range(1, 6);
                for (int i = 0; i < pool_size; i++)
                    key_pool[i] = $urandom;
                key_pool[0] = KEY_MIN;
                key_pool[1] = KEY_MAX;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = t_cmd'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    key = $urandom;
                issue_command(cmd, key, $urandom);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_lru_tiebreak.sv
bench/lfu_cache_checker.sv
bench/tb.sv
